### rtl/fcmb_pkg.sv
package fcmb_pkg;

    localparam int DEPTH_DEFAULT    = 256;
    localparam int KEY_BITS_DEFAULT = 64;

    // Field widths of the channels and the configuration port.
    localparam int LOOKUP_KEY_W = 64;
    localparam int STATUS_W     = 2;
    localparam int SLOT_W       = 8;
    localparam int DROPPED_W    = 8;
    localparam int MPT_W        = 8;
    localparam int KEEP_LIMIT_W = 9;
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [MPT_W-1:0] MPT_RESET        = 8'd4;
    localparam int               KEEP_LIMIT_RESET = 256;

    localparam logic [CFG_INDEX_W-1:0] REG_MISSES_PER_TURN = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEEP_LIMIT      = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_TURN  = 2'd0,
        STAT_HIT   = 2'd1,
        STAT_FILL  = 2'd2,
        STAT_DEFER = 2'd3
    } status_t;

    typedef struct packed {
        logic accept;
        logic scan;
        logic hit_take;
        logic defer;
        logic drop;
        logic write;
        logic load_out;
    } fcmb_cmd_t;

    typedef struct packed {
        logic in_mode;
        logic hit;
        logic scan_done;
        logic over_budget;
    } fcmb_sts_t;

endpackage

### rtl/fcmb_ifs.sv
interface fcmb_req_if;
    logic                                valid;
    logic                                ready;
    logic                                mode;
    logic [fcmb_pkg::LOOKUP_KEY_W-1:0]   lookup_key;

    modport source (output valid, output mode, output lookup_key, input ready);
    modport sink   (input valid, input mode, input lookup_key, output ready);
endinterface

interface fcmb_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [fcmb_pkg::STATUS_W-1:0]       status;
    logic [fcmb_pkg::SLOT_W-1:0]         slot;
    logic [fcmb_pkg::DROPPED_W-1:0]      dropped_count;
    logic                                ran_out;

    modport source (output valid, output status, output slot, output dropped_count,
                    output ran_out, input ready);
    modport sink   (input valid, input status, input slot, input dropped_count,
                    input ran_out, output ready);
endinterface

### rtl/fcmb_ctrl.sv
module fcmb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  fcmb_pkg::fcmb_sts_t sts,
    output fcmb_pkg::fcmb_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FILL = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.accept   = (state_reg == S_IDLE) && req_valid;
        cmd.scan     = (state_reg == S_SCAN);
        cmd.load_out = (state_reg == S_RESP) && (!out_valid_reg || rsp_ready);
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = sts.in_mode ? S_SCAN : S_RESP;
                end
            end
            S_SCAN:
            begin
                if (sts.hit)
                begin
                    cmd.hit_take = 1'b1;
                    state_next   = S_RESP;
                end
                else if (sts.scan_done)
                begin
                    if (sts.over_budget)
                    begin
                        cmd.defer  = 1'b1;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cmd.drop   = 1'b1;
                        state_next = S_FILL;
                    end
                end
            end
            S_FILL:
            begin
                cmd.write  = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (cmd.load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    a_hit_goes_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && sts.hit) |=> (state_reg == S_RESP))
        else $error("hit in scan did not move to response");

    a_fill_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |=> (state_reg == S_RESP))
        else $error("fill did not complete in one cycle");

    a_free_slot_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && !out_valid_reg) |=> out_valid_reg)
        else $error("free output register was not loaded");

endmodule

### rtl/fcmb_datapath.sv
module fcmb_datapath #(
    parameter int DEPTH    = fcmb_pkg::DEPTH_DEFAULT,
    parameter int KEY_BITS = fcmb_pkg::KEY_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fcmb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fcmb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                req_mode,
    input  logic [fcmb_pkg::LOOKUP_KEY_W-1:0]   req_key,
    input  fcmb_pkg::fcmb_cmd_t                 cmd,
    output fcmb_pkg::fcmb_sts_t                 sts,
    output logic [fcmb_pkg::STATUS_W-1:0]       out_status,
    output logic [fcmb_pkg::SLOT_W-1:0]         out_slot,
    output logic [fcmb_pkg::DROPPED_W-1:0]      out_dropped,
    output logic                                out_ran_out
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int SUM_W = OCC_W + 1;
    localparam int CMP_W = (OCC_W > fcmb_pkg::KEEP_LIMIT_W) ? OCC_W : fcmb_pkg::KEEP_LIMIT_W;

    localparam int LIMIT_RESET_I = (fcmb_pkg::KEEP_LIMIT_RESET > DEPTH) ? DEPTH
                                 : fcmb_pkg::KEEP_LIMIT_RESET;
    localparam int DROP_RESET_I  = (LIMIT_RESET_I / 2 < 1) ? 1 : LIMIT_RESET_I / 2;

    localparam logic [OCC_W-1:0] LIMIT_RESET = OCC_W'(LIMIT_RESET_I);
    localparam logic [OCC_W-1:0] DROP_RESET  = OCC_W'(DROP_RESET_I);
    localparam logic [CMP_W-1:0] DEPTH_CMP   = CMP_W'(DEPTH);
    localparam logic [OCC_W-1:0] DEPTH_OCC   = OCC_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_POS    = PTR_W'(DEPTH - 1);

    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                  input logic [OCC_W-1:0] offset);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(offset);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    logic [KEY_BITS-1:0]            ring_mem [DEPTH];

    logic [fcmb_pkg::MPT_W-1:0]     mpt_reg;
    logic [OCC_W-1:0]               limit_reg;
    logic [OCC_W-1:0]               drop_n_reg;
    logic [PTR_W-1:0]               oldest_reg;
    logic [OCC_W-1:0]               occ_reg;
    logic [fcmb_pkg::MPT_W-1:0]     misses_reg;
    logic                           flag_reg;
    logic [OCC_W-1:0]               issue_cnt_reg;
    logic                           rd_valid_reg;

    logic [KEY_BITS-1:0]            key_reg;
    logic [PTR_W-1:0]               scan_pos_reg;
    logic [PTR_W-1:0]               rd_pos_reg;
    logic [KEY_BITS-1:0]            rd_data_reg;
    fcmb_pkg::status_t              res_status_reg;
    logic [PTR_W-1:0]               res_slot_reg;
    logic [OCC_W-1:0]               res_drop_reg;
    logic [fcmb_pkg::STATUS_W-1:0]  out_status_reg;
    logic [fcmb_pkg::SLOT_W-1:0]    out_slot_reg;
    logic [fcmb_pkg::DROPPED_W-1:0] out_dropped_reg;
    logic                           out_ran_out_reg;

    logic [CMP_W-1:0]               kl_ext;
    logic [CMP_W-1:0]               kl_clamped;
    logic [OCC_W-1:0]               limit_next;
    logic [OCC_W-1:0]               half_limit;
    logic [OCC_W-1:0]               drop_n_next;
    logic                           issue_ok;
    logic                           drop_needed;
    logic [PTR_W-1:0]               wr_pos;

    // The keep limit is clamped to 1..DEPTH as it is written, and the drop
    // size is worked out once, so neither sits in the fill path.
    always_comb
    begin
        kl_ext = CMP_W'(cfg_wdata[fcmb_pkg::KEEP_LIMIT_W-1:0]);
        if (kl_ext == '0)
        begin
            kl_clamped = CMP_W'(1);
        end
        else if (kl_ext > DEPTH_CMP)
        begin
            kl_clamped = DEPTH_CMP;
        end
        else
        begin
            kl_clamped = kl_ext;
        end
        limit_next  = kl_clamped[OCC_W-1:0];
        half_limit  = limit_next >> 1;
        drop_n_next = (half_limit == '0) ? OCC_W'(1) : half_limit;
    end

    assign issue_ok    = (issue_cnt_reg < occ_reg);
    assign drop_needed = (occ_reg >= limit_reg);
    assign wr_pos      = ring_add(oldest_reg, occ_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mpt_reg       <= fcmb_pkg::MPT_RESET;
            limit_reg     <= LIMIT_RESET;
            drop_n_reg    <= DROP_RESET;
            oldest_reg    <= '0;
            occ_reg       <= '0;
            misses_reg    <= '0;
            flag_reg      <= 1'b0;
            issue_cnt_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fcmb_pkg::REG_MISSES_PER_TURN:
                    begin
                        mpt_reg <= cfg_wdata[fcmb_pkg::MPT_W-1:0];
                    end
                    fcmb_pkg::REG_KEEP_LIMIT:
                    begin
                        limit_reg  <= limit_next;
                        drop_n_reg <= drop_n_next;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.accept && !req_mode)
            begin
                misses_reg <= '0;
                flag_reg   <= 1'b0;
            end
            if (cmd.defer)
            begin
                flag_reg <= 1'b1;
            end
            if (cmd.drop)
            begin
                misses_reg <= misses_reg + 1'b1;
                if (drop_needed)
                begin
                    oldest_reg <= ring_add(oldest_reg, drop_n_reg);
                    occ_reg    <= occ_reg - drop_n_reg;
                end
            end
            if (cmd.write)
            begin
                occ_reg <= occ_reg + 1'b1;
            end
            if (cmd.accept)
            begin
                issue_cnt_reg <= '0;
                rd_valid_reg  <= 1'b0;
            end
            else if (cmd.scan)
            begin
                rd_valid_reg <= issue_ok;
                if (issue_ok)
                begin
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                end
            end
            else
            begin
                rd_valid_reg <= 1'b0;
            end
        end
    end

    // Tag store: one write port for fills, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            ring_mem[wr_pos] <= key_reg;
        end
        if (cmd.scan && issue_ok)
        begin
            rd_data_reg <= ring_mem[scan_pos_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg        <= req_key[KEY_BITS-1:0];
            scan_pos_reg   <= oldest_reg;
            res_status_reg <= fcmb_pkg::STAT_TURN;
            res_slot_reg   <= '0;
            res_drop_reg   <= '0;
        end
        if (cmd.scan && issue_ok)
        begin
            scan_pos_reg <= (scan_pos_reg == LAST_POS) ? '0 : scan_pos_reg + 1'b1;
            rd_pos_reg   <= scan_pos_reg;
        end
        if (cmd.hit_take)
        begin
            res_status_reg <= fcmb_pkg::STAT_HIT;
            res_slot_reg   <= rd_pos_reg;
        end
        if (cmd.defer)
        begin
            res_status_reg <= fcmb_pkg::STAT_DEFER;
        end
        if (cmd.drop)
        begin
            res_drop_reg <= drop_needed ? drop_n_reg : '0;
        end
        if (cmd.write)
        begin
            res_status_reg <= fcmb_pkg::STAT_FILL;
            res_slot_reg   <= wr_pos;
        end
        if (cmd.load_out)
        begin
            out_status_reg  <= res_status_reg;
            out_slot_reg    <= fcmb_pkg::SLOT_W'(res_slot_reg);
            out_dropped_reg <= fcmb_pkg::DROPPED_W'(res_drop_reg);
            out_ran_out_reg <= flag_reg;
        end
    end

    assign sts.in_mode     = req_mode;
    assign sts.hit         = rd_valid_reg && (rd_data_reg == key_reg);
    assign sts.scan_done   = !rd_valid_reg && !issue_ok;
    assign sts.over_budget = (misses_reg >= mpt_reg);

    assign out_status  = out_status_reg;
    assign out_slot    = out_slot_reg;
    assign out_dropped = out_dropped_reg;
    assign out_ran_out = out_ran_out_reg;

    a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= DEPTH_OCC)
        else $error("occupancy above ring depth");

    a_fill_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> (occ_reg < DEPTH_OCC))
        else $error("fill into a full ring");

    a_compare_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(cmd.scan))
        else $error("tag compare without a scan read");

endmodule

### rtl/fifo_cache_with_miss_budget_top.sv
// Fully associative tag store with FIFO replacement and a per-turn miss
// budget. A lookup scans the stored keys oldest first through the single
// read port of the tag memory, one entry a cycle. One beat is worked on at
// a time; the next one is accepted as soon as the result has moved to the
// output register, even while that register still waits to be taken.
// Configuration is to be written only while no beat is in progress.
module fifo_cache_with_miss_budget_top #(
    parameter int DEPTH    = fcmb_pkg::DEPTH_DEFAULT,
    parameter int KEY_BITS = fcmb_pkg::KEY_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fcmb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fcmb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    fcmb_req_if.sink                         req,
    fcmb_rsp_if.source                       rsp
);

    fcmb_pkg::fcmb_cmd_t cmd;
    fcmb_pkg::fcmb_sts_t sts;

    fcmb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    fcmb_datapath #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .req_mode    (req.mode),
        .req_key     (req.lookup_key),
        .cmd         (cmd),
        .sts         (sts),
        .out_status  (rsp.status),
        .out_slot    (rsp.slot),
        .out_dropped (rsp.dropped_count),
        .out_ran_out (rsp.ran_out)
    );

endmodule

### tb/sv/fifo_cache_with_miss_budget_top_tb.sv
module fifo_cache_with_miss_budget_top_tb;

    localparam int RING_DEPTH  = fcmb_pkg::DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int NUM_PHASES  = 6;

    typedef struct {
        logic                              mode;
        logic [fcmb_pkg::LOOKUP_KEY_W-1:0] key;
    } lookup_beat_t;

    typedef struct {
        fcmb_pkg::status_t              status;
        logic [fcmb_pkg::SLOT_W-1:0]    slot;
        logic [fcmb_pkg::DROPPED_W-1:0] dropped;
        logic                           ran_out;
    } tag_result_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [fcmb_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [fcmb_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    fcmb_req_if req_bus ();
    fcmb_rsp_if rsp_bus ();

    fifo_cache_with_miss_budget_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_bus),
        .rsp       (rsp_bus)
    );

    // Shadow copy of the tag store and its settings.
    logic [fcmb_pkg::LOOKUP_KEY_W-1:0] shadow_keys [RING_DEPTH];
    int unsigned                       ring_head;
    int unsigned                       ring_fill;
    int unsigned                       turn_misses;
    bit                                out_of_budget;
    int unsigned                       miss_budget;
    int unsigned                       keep_limit;

    lookup_beat_t                      pending_beats [$];
    tag_result_t                       tag_results_due [$];
    logic [fcmb_pkg::LOOKUP_KEY_W-1:0] recent_keys [$];

    int unsigned beats_offered;
    int unsigned beats_accepted;
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic tag_result_t lookup_outcome(
        input logic                              mode,
        input logic [fcmb_pkg::LOOKUP_KEY_W-1:0] key);
        tag_result_t r;
        int unsigned lim;
        int unsigned n;
        int unsigned pos;
        bit          found;
        r.status  = fcmb_pkg::STAT_TURN;
        r.slot    = '0;
        r.dropped = '0;
        found     = 1'b0;
        if (mode == 1'b0)
        begin
            turn_misses   = 0;
            out_of_budget = 1'b0;
        end
        else
        begin
            // Oldest first, so the first match is the one the block reports.
            for (int unsigned i = 0; i < ring_fill && !found; i++)
            begin
                pos = (ring_head + i) % RING_DEPTH;
                if (shadow_keys[pos] == key)
                begin
                    found  = 1'b1;
                    r.slot = fcmb_pkg::SLOT_W'(pos);
                end
            end
            if (found)
            begin
                r.status = fcmb_pkg::STAT_HIT;
            end
            else if (turn_misses >= miss_budget)
            begin
                out_of_budget = 1'b1;
                r.status      = fcmb_pkg::STAT_DEFER;
            end
            else
            begin
                turn_misses = (turn_misses + 1) & 8'hFF;
                lim = keep_limit;
                if (lim < 1)
                    lim = 1;
                if (lim > RING_DEPTH)
                    lim = RING_DEPTH;
                if (ring_fill >= lim)
                begin
                    n = lim / 2;
                    if (n < 1)
                        n = 1;
                    if (n > ring_fill)
                        n = ring_fill;
                    ring_head = (ring_head + n) % RING_DEPTH;
                    ring_fill = ring_fill - n;
                    r.dropped = fcmb_pkg::DROPPED_W'(n);
                end
                pos = (ring_head + ring_fill) % RING_DEPTH;
                shadow_keys[pos] = key;
                ring_fill = ring_fill + 1;
                r.slot   = fcmb_pkg::SLOT_W'(pos);
                r.status = fcmb_pkg::STAT_FILL;
            end
        end
        r.ran_out = out_of_budget;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 40)
            $display("mismatch on %s at cycle %0d: got %0h, want %0h",
                     field, cycle_count, got, want);
    endtask

    // Monitor: checks each result beat, then predicts for each request beat.
    always @(posedge clk)
    begin : monitor
        tag_result_t want;
        if (rst_n === 1'b1)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (tag_results_due.size() == 0)
                begin
                    report_mismatch("unexpected result", 64'(rsp_bus.status), 64'(0));
                end
                else
                begin
                    want = tag_results_due[0];
                    tag_results_due.delete(0);
                    if (rsp_bus.status !== want.status)
                        report_mismatch("status", 64'(rsp_bus.status), 64'(want.status));
                    if (rsp_bus.slot !== want.slot)
                        report_mismatch("slot", 64'(rsp_bus.slot), 64'(want.slot));
                    if (rsp_bus.dropped_count !== want.dropped)
                        report_mismatch("dropped_count", 64'(rsp_bus.dropped_count),
                                        64'(want.dropped));
                    if (rsp_bus.ran_out !== want.ran_out)
                        report_mismatch("ran_out", 64'(rsp_bus.ran_out), 64'(want.ran_out));
                end
            end
            if (req_bus.valid && req_bus.ready)
            begin
                tag_results_due = {tag_results_due,
                                   lookup_outcome(req_bus.mode, req_bus.lookup_key)};
                beats_accepted = beats_accepted + 1;
            end
        end
    end

    // Driver: a beat on offer is held until the monitor has seen it taken.
    always @(negedge clk)
    begin : driver
        lookup_beat_t nxt;
        bit           held;
        held = req_bus.valid && (beats_accepted != beats_offered);
        if (rst_n !== 1'b1)
        begin
            req_bus.valid <= 1'b0;
        end
        else if (!held)
        begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                nxt = pending_beats[0];
                pending_beats.delete(0);
                req_bus.valid      <= 1'b1;
                req_bus.mode       <= nxt.mode;
                req_bus.lookup_key <= nxt.key;
                beats_offered = beats_offered + 1;
            end
            else
            begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        rsp_bus.ready <= (rst_n === 1'b1) && ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic logic [fcmb_pkg::LOOKUP_KEY_W-1:0] fresh_key();
        return {$urandom, $urandom};
    endfunction

    // Either a new key or one of the recently used ones, which are likely still stored.
    function automatic logic [fcmb_pkg::LOOKUP_KEY_W-1:0] pick_key(
        input int unsigned new_pct);
        int unsigned span;
        if (recent_keys.size() == 0 || $urandom_range(99) < new_pct)
            return fresh_key();
        span = recent_keys.size() - 1;
        if (span > 24)
            span = 24;
        return recent_keys[recent_keys.size() - 1 - $urandom_range(span)];
    endfunction

    task automatic push_beat(input logic mode,
                             input logic [fcmb_pkg::LOOKUP_KEY_W-1:0] key);
        lookup_beat_t b;
        b.mode = mode;
        b.key  = key;
        pending_beats = {pending_beats, b};
        if (mode)
        begin
            recent_keys = {recent_keys, key};
            if (recent_keys.size() > 64)
                recent_keys.delete(0);
        end
    endtask

    // Mostly a begin-turn beat followed by a run of lookups; now and then a run
    // carries on the previous turn, and long runs overrun small budgets.
    task automatic queue_turns(input int unsigned count, input int unsigned new_pct);
        int unsigned made;
        int unsigned run;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(9) != 0)
            begin
                push_beat(1'b0, fresh_key());
                made = made + 1;
            end
            run = $urandom_range(12, 1);
            repeat (run)
            begin
                push_beat(1'b1, pick_key(new_pct));
                made = made + 1;
            end
        end
    endtask

    task automatic wait_until_idle();
        while (pending_beats.size() != 0 || beats_accepted != beats_offered ||
               tag_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [fcmb_pkg::CFG_INDEX_W-1:0] index,
                                  input int unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= fcmb_pkg::CFG_DATA_W'(value);
        if (index == fcmb_pkg::REG_MISSES_PER_TURN)
            miss_budget = value & 8'hFF;
        else
            keep_limit = value & 9'h1FF;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin : main
        int unsigned phase_budget [NUM_PHASES];
        int unsigned phase_limit  [NUM_PHASES];
        int unsigned phase_items  [NUM_PHASES];
        int unsigned phase_new    [NUM_PHASES];
        phase_budget = '{3, 255, 0, 6, 2, 17};
        phase_limit  = '{8, 256, 5, 511, 1, 37};
        phase_items  = '{150, 340, 130, 160, 130, 190};
        phase_new    = '{40, 95, 50, 60, 50, 35};

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_wdata          = '0;
        req_bus.valid      = 1'b0;
        req_bus.mode       = 1'b0;
        req_bus.lookup_key = '0;
        rsp_bus.ready      = 1'b0;
        cycle_count        = 0;
        beats_offered      = 0;
        beats_accepted     = 0;
        mismatch_count     = 0;
        ring_head          = 0;
        ring_fill          = 0;
        turn_misses        = 0;
        out_of_budget      = 1'b0;
        miss_budget        = fcmb_pkg::MPT_RESET;
        keep_limit         = fcmb_pkg::KEEP_LIMIT_RESET;
        tx_idle_pct        = 17;
        rx_idle_pct        = 69;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: fill up to the budget, a hit, a deferral and its sticky flag.
        push_beat(1'b0, '1);
        push_beat(1'b1, '0);
        push_beat(1'b1, '1);
        push_beat(1'b1, '0);
        push_beat(1'b1, 64'h1);
        push_beat(1'b1, 64'h8000_0000_0000_0000);
        push_beat(1'b1, 64'h2);
        push_beat(1'b1, '1);
        push_beat(1'b0, '0);
        wait_until_idle();

        // Zero budget, and a keep limit of zero which behaves as one.
        write_register(fcmb_pkg::REG_MISSES_PER_TURN, 0);
        write_register(fcmb_pkg::REG_KEEP_LIMIT, 0);
        push_beat(1'b1, 64'h3);
        push_beat(1'b1, '0);
        push_beat(1'b0, fresh_key());
        wait_until_idle();

        write_register(fcmb_pkg::REG_MISSES_PER_TURN, 255);
        push_beat(1'b1, 64'h5);
        push_beat(1'b1, 64'h6);
        push_beat(1'b1, 64'h5);
        wait_until_idle();

        write_register(fcmb_pkg::REG_KEEP_LIMIT, 2);
        push_beat(1'b1, 64'h7);
        push_beat(1'b1, 64'h8);
        push_beat(1'b1, 64'h9);
        wait_until_idle();

        // A limit above the ring depth is clamped to it.
        write_register(fcmb_pkg::REG_KEEP_LIMIT, 511);
        push_beat(1'b1, 64'hA);
        push_beat(1'b1, 64'h7);
        wait_until_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p < 2)
            begin
                tx_idle_pct = 17;
                rx_idle_pct = 69;
            end
            else if (p < 4)
            begin
                tx_idle_pct = 69;
                rx_idle_pct = 17;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_register(fcmb_pkg::REG_MISSES_PER_TURN, phase_budget[p]);
            write_register(fcmb_pkg::REG_KEEP_LIMIT, phase_limit[p]);
            // The sender holds off half way until every result is back.
            queue_turns(phase_items[p] / 2, phase_new[p]);
            wait_until_idle();
            queue_turns(phase_items[p] - phase_items[p] / 2, phase_new[p]);
            wait_until_idle();
        end

        repeat (RING_DEPTH + 8) @(posedge clk);
        if (mismatch_count == 0 && tag_results_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
rtl/fcmb_pkg.sv
rtl/fcmb_ifs.sv
rtl/fcmb_ctrl.sv
rtl/fcmb_datapath.sv
rtl/fifo_cache_with_miss_budget_top.sv
tb/sv/fifo_cache_with_miss_budget_top_tb.sv
